// ----- rtl/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpc_pkg: shared types for the relation property checker
// Transfer payloads, the lane control and status groups, the sequencer
// states and a bit pick helper used by the lanes.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int unsigned RowW = 16;
  localparam int unsigned SizeW = 5;
  localparam logic [SizeW-1:0] SizeReset = SizeW'(16);

  // one input transfer: a matrix row and the end marker
  typedef struct packed {
    logic [RowW-1:0] row_bits;
    logic            last_row;
  } in_t;

  // one result transfer
  typedef struct packed {
    logic is_symmetric;
    logic is_reflexive;
    logic is_transitive;
  } out_t;

  // control broadcast to every lane
  typedef struct packed {
    logic clear;
    logic step;
  } lane_ctrl_t;

  // what one lane found about its row
  typedef struct packed {
    logic sym;
    logic refl;
    logic trans;
  } lane_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DONE
  } state_e;

  // bit idx of a row, zero for columns the row cannot carry
  function automatic logic bit_at(logic [RowW-1:0] v, logic [31:0] idx);
    logic b;
    b = 1'b0;
    if (idx < 32'(RowW)) begin
      b = v[idx[3:0]];
    end
    return b;
  endfunction

endpackage

// ----- rtl/relation_property_checker.sv -----
// ----------------------------------------------------------------------------
// relation_property_checker: reflexive, symmetric and transitive test
// Loads a 0/1 relation matrix one row per transfer and reports the three
// properties on the row marked last.
// ----------------------------------------------------------------------------
// Rows are taken one per cycle while the block is idle. The transfer that
// carries last_row starts an evaluation that holds off input until the result
// is loaded: one lane per row works in parallel while a sequencer walks the
// column index k over the n columns in use, n being the size in use,
// broadcasting row k through one read mux to all lanes; a merge state then
// loads the lane findings into the result register. A result that is not
// taken keeps the block in that merge state. The row store needs no
// clearing pass: a fill count marks present rows and is reset after each result.
module relation_property_checker import rpc_pkg::*; #(
  parameter int unsigned MAX_N = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_data_i
);

  localparam int unsigned NW = $clog2(MAX_N + 1);
  localparam int unsigned KW = $clog2(MAX_N);

  state_e           state_q, state_d;
  logic [SizeW-1:0] size_q;
  logic [NW-1:0]    count_q, count_d;
  logic [KW-1:0]    k_q, k_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_data_q, out_data_d;

  logic             in_xfer;
  logic             out_free;
  logic [NW-1:0]    n_eff;
  logic [RowW-1:0]  col_mask;
  logic [RowW-1:0]  bcast;
  lane_ctrl_t       ctrl;
  logic [RowW-1:0]  lane_row  [MAX_N];
  lane_stat_t       lane_stat [MAX_N];
  out_t             merged;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_we_i) begin
      size_q <= cfg_data_i;
    end
  end

  // effective size, zero taken as one, saturated at the lane count
  always_comb begin
    if (size_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(size_q) > 32'(MAX_N)) begin
      n_eff = NW'(MAX_N);
    end else begin
      n_eff = NW'(size_q);
    end
  end

  // columns in use
  always_comb begin
    for (int j = 0; j < int'(RowW); j++) begin
      col_mask[j] = 32'(j) < 32'(n_eff);
    end
  end

  assign ctrl.clear = in_xfer && in_data_i.last_row;
  assign ctrl.step  = state_q == ST_EVAL;
  assign bcast      = lane_row[k_q];

  // row lanes
  for (genvar g = 0; g < int'(MAX_N); g++) begin : g_lane
    rpc_lane #(
      .MAX_N (MAX_N),
      .LANE  (g)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (in_xfer && (32'(count_q) == 32'(g))),
      .wr_data_i  (in_data_i.row_bits),
      .count_i    (count_q),
      .size_i     (n_eff),
      .col_mask_i (col_mask),
      .ctrl_i     (ctrl),
      .k_i        (k_q),
      .bcast_i    (bcast),
      .row_o      (lane_row[g]),
      .stat_o     (lane_stat[g])
    );
  end

  rpc_merge #(
    .MAX_N (MAX_N)
  ) u_merge (
    .stat_i   (lane_stat),
    .result_o (merged)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_data_i.last_row) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (32'(k_q) + 32'd1 >= 32'(n_eff)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    count_d     = count_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        k_d = '0;
        if (in_xfer && (32'(count_q) < 32'(MAX_N))) begin
          count_d = count_q + NW'(1);
        end
      end
      ST_EVAL: begin
        k_d = k_q + KW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = merged;
          count_d     = '0;
        end
      end
      default: begin
        k_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(MAX_N))
    else $error("row count above lane count");

  a_last_starts_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.last_row) |=> (state_q == ST_EVAL))
    else $error("last row did not start evaluation");

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> (32'(k_q) < 32'(n_eff)))
    else $error("column walk beyond size");

  a_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_o && count_q == '0))
    else $error("result not loaded or store not cleared");

endmodule

// ----- rtl/rpc_lane.sv -----
// ----------------------------------------------------------------------------
// rpc_lane: one matrix row and its share of the property tests
// Holds row LANE, and while the sequencer walks k it checks symmetry against
// the broadcast row k and collects the two-step reach of this row.
// ----------------------------------------------------------------------------
module rpc_lane import rpc_pkg::*; #(
  parameter int unsigned MAX_N = 16,
  parameter int unsigned LANE  = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [RowW-1:0]              wr_data_i,
  input  logic [$clog2(MAX_N+1)-1:0]   count_i,
  input  logic [$clog2(MAX_N+1)-1:0]   size_i,
  input  logic [RowW-1:0]              col_mask_i,
  input  lane_ctrl_t                   ctrl_i,
  input  logic [$clog2(MAX_N)-1:0]     k_i,
  input  logic [RowW-1:0]              bcast_i,
  output logic [RowW-1:0]              row_o,
  output lane_stat_t                   stat_o
);

  logic [RowW-1:0] row_q;
  logic [RowW-1:0] reach_q, reach_d;
  logic            sym_q, sym_d;
  logic            active;
  logic            present;
  logic            bit_ik;
  logic            bit_ki;

  // row storage, payload only
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      row_q <= wr_data_i;
    end
  end

  // rows that never arrived or lie beyond the size read as zero
  assign active  = 32'(LANE) < 32'(size_i);
  assign present = active && (32'(LANE) < 32'(count_i));
  assign row_o   = present ? (row_q & col_mask_i) : '0;

  assign bit_ik = bit_at(row_o, 32'(k_i));
  assign bit_ki = bit_at(bcast_i, 32'(LANE));

  // per step accumulation
  always_comb begin
    sym_d   = sym_q;
    reach_d = reach_q;
    if (ctrl_i.clear) begin
      sym_d   = 1'b1;
      reach_d = '0;
    end else if (ctrl_i.step) begin
      sym_d = sym_q & (bit_ik == bit_ki);
      if (bit_ik) begin
        reach_d = reach_q | bcast_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q   <= 1'b1;
      reach_q <= '0;
    end else begin
      sym_q   <= sym_d;
      reach_q <= reach_d;
    end
  end

  // lanes outside the size pass every test
  assign stat_o.sym   = !active | sym_q;
  assign stat_o.refl  = !active | bit_at(row_o, 32'(LANE));
  assign stat_o.trans = !active | ((reach_q & ~row_o) == '0);

endmodule

// ----- rtl/rpc_merge.sv -----
// ----------------------------------------------------------------------------
// rpc_merge: combines the lane findings
// A relation has a property only when every lane reports it.
// ----------------------------------------------------------------------------
module rpc_merge import rpc_pkg::*; #(
  parameter int unsigned MAX_N = 16
) (
  input  lane_stat_t stat_i [MAX_N],
  output out_t       result_o
);

  // and-reduce across lanes
  always_comb begin
    result_o.is_symmetric  = 1'b1;
    result_o.is_reflexive  = 1'b1;
    result_o.is_transitive = 1'b1;
    for (int i = 0; i < int'(MAX_N); i++) begin
      result_o.is_symmetric  = result_o.is_symmetric  & stat_i[i].sym;
      result_o.is_reflexive  = result_o.is_reflexive  & stat_i[i].refl;
      result_o.is_transitive = result_o.is_transitive & stat_i[i].trans;
    end
  end

endmodule

// ----- verif/relation_property_monitor.sv -----
// ----------------------------------------------------------------------------
// relation_property_monitor: result prediction for the relation checker
// Watches the row, result and size register ports, keeps its own copy of the
// row store and the size, predicts the three property flags on every row
// marked last and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module relation_property_monitor
  import rpc_pkg::*;
#(
  parameter int unsigned MAX_N = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_t              in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_t             out_data_i,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [MAX_N-1:0][RowW-1:0] relation_t;

  // mirrored store, fill count and size register
  relation_t        rows_q;
  int unsigned      rows_seen;
  logic [SizeW-1:0] size_q;
  out_t             flags_due[$];
  int               fails;

  // property flags of the first n rows and columns, n taken from the size
  function automatic out_t relation_flags(relation_t rows, logic [SizeW-1:0] size);
    int unsigned     n, i, j, k;
    logic [RowW-1:0] mask, reach;
    relation_t       m;
    out_t            f;
    n = (size == '0) ? 1 : ((int'(size) > MAX_N) ? MAX_N : int'(size));
    mask = (n >= RowW) ? '1 : RowW'((32'd1 << n) - 32'd1);
    f = '1;
    for (i = 0; i < MAX_N; i++) begin
      m[i] = (i < n) ? (rows[i] & mask) : '0;
    end
    for (i = 0; i < n; i++) begin
      if (!m[i][i]) begin
        f.is_reflexive = 1'b0;
      end
      for (j = 0; j < n; j++) begin
        if (m[i][j] != m[j][i]) begin
          f.is_symmetric = 1'b0;
        end
      end
      // everything reachable from row i in two steps
      reach = '0;
      for (k = 0; k < n; k++) begin
        if (m[i][k]) begin
          reach |= m[k];
        end
      end
      if ((reach & ~m[i] & mask) != '0) begin
        f.is_transitive = 1'b0;
      end
    end
    return f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t due;
    if (!rst_ni) begin
      rows_q = '0;
      rows_seen = 0;
      size_q = SizeReset;
      flags_due.delete();
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        size_q = cfg_data_i;
      end

      // row transfer: store while there is room, evaluate on the last row
      if (in_valid_i && !in_stall_i) begin
        if (rows_seen < MAX_N) begin
          rows_q[rows_seen] = in_data_i.row_bits;
          rows_seen++;
        end
        if (in_data_i.last_row) begin
          flags_due.push_back(relation_flags(rows_q, size_q));
          rows_q = '0;
          rows_seen = 0;
        end
      end

      // result transfer against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (flags_due.size() == 0) begin
          $error("result transfer with nothing predicted: sym %0b refl %0b trans %0b",
                 out_data_i.is_symmetric, out_data_i.is_reflexive,
                 out_data_i.is_transitive);
          fails++;
        end else begin
          due = flags_due.pop_front();
          if (out_data_i.is_symmetric !== due.is_symmetric) begin
            $error("is_symmetric: expected %0b, actual %0b",
                   due.is_symmetric, out_data_i.is_symmetric);
            fails++;
          end
          if (out_data_i.is_reflexive !== due.is_reflexive) begin
            $error("is_reflexive: expected %0b, actual %0b",
                   due.is_reflexive, out_data_i.is_reflexive);
            fails++;
          end
          if (out_data_i.is_transitive !== due.is_transitive) begin
            $error("is_transitive: expected %0b, actual %0b",
                   due.is_transitive, out_data_i.is_transitive);
            fails++;
          end
        end
      end

      pending_o <= flags_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ----- verif/tb_relation_property_checker.sv -----
// ----------------------------------------------------------------------------
// tb_relation_property_checker: regression for the relation property checker
// Drives directed and random relation matrices under several size settings,
// with random row gaps, random result back-pressure and one long result
// hold-off; the monitor beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_relation_property_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import rpc_pkg::*;

  localparam int unsigned MaxN = 16;
  localparam int unsigned TargetRows = 650;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdleLimit = 2000;

  typedef logic [MaxN-1:0][RowW-1:0] relation_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_t              in_data;
  logic             out_valid;
  logic             out_stall;
  out_t             out_data;
  logic             cfg_we;
  logic [SizeW-1:0] cfg_data;
  int               fail_count;
  int               pending_results;

  // pacing shared by sender and receiver
  bit               no_idle = 1'b0;
  int unsigned      hold_req = 0;
  int unsigned      rows_loaded = 0;
  int unsigned      fill = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  relation_property_checker #(.MAX_N(MaxN)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  relation_property_monitor #(.MAX_N(MaxN)) u_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  // one row transfer after a random gap; returns at the accepting edge
  task automatic send_row(input logic [RowW-1:0] bits, input logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{row_bits: bits, last_row: last};
    do @(posedge clk); while (in_stall);
    if (fill < MaxN) begin
      rows_loaded++;
    end
    fill = last ? 0 : ((fill < MaxN) ? fill + 1 : fill);
  endtask

  // wait until every predicted result has come out and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_size(input logic [SizeW-1:0] value);
    settle();
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random n x n relation, optionally closed under the three properties
  function automatic relation_t make_relation(int unsigned n);
    int unsigned     i, j, k, dens;
    logic [RowW-1:0] mask;
    relation_t       m;
    m = '0;
    dens = $urandom_range(0, 4);
    mask = (n >= RowW) ? '1 : RowW'((32'd1 << n) - 32'd1);
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        m[i][j] = ($urandom_range(0, 3) < dens);
      end
    end
    if ($urandom_range(0, 1)) begin
      for (i = 0; i < n; i++) begin
        m[i][i] = 1'b1;
      end
    end
    if ($urandom_range(0, 1)) begin
      for (i = 0; i < n; i++) begin
        for (j = 0; j < n; j++) begin
          if (m[i][j]) begin
            m[j][i] = 1'b1;
          end
        end
      end
    end
    // transitive closure
    if ($urandom_range(0, 1)) begin
      for (k = 0; k < n; k++) begin
        for (i = 0; i < n; i++) begin
          if (m[i][k]) begin
            m[i] |= m[k];
          end
        end
      end
    end
    // junk in the columns past the size
    if ($urandom_range(0, 3) == 0) begin
      for (i = 0; i < n; i++) begin
        m[i] |= RowW'($urandom_range(0, 16'hFFFF)) & ~mask;
      end
    end
    return m;
  endfunction

  // result side: random hold-off per transfer, sometimes after valid shows up
  initial begin : result_sink
    int unsigned wait_n;
    bit          after_valid;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      wait_n = no_idle ? 0 : $urandom_range(0, 18);
      wait_n += hold_req;
      hold_req = 0;
      after_valid = $urandom_range(0, 1);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        if (after_valid) begin
          do @(posedge clk); while (!out_valid);
        end
        repeat (wait_n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int unsigned idle_run;
    idle_run = 0;
    while (idle_run < IdleLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("relation_property_checker regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [SizeW-1:0] size_v;
    int unsigned      n_eff, mats, kind, cnt, i;
    relation_t        rel;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one full row at the reset size, the rest missing
    send_row(16'hFFFF, 1'b1);
    // size zero acts as size one; upper bits are ignored
    set_size('0);
    send_row(16'h0001, 1'b1);
    send_row(16'hFFFE, 1'b1);
    // oversized setting saturates; identity over all rows
    set_size(5'd31);
    for (i = 0; i < MaxN; i++) begin
      send_row(RowW'(1) << i, i == MaxN - 1);
    end
    // two-step pair missing from the relation
    set_size(5'd2);
    send_row(16'h0002, 1'b0);
    send_row(16'h0001, 1'b1);

    // long result hold-off while single-row matrices keep coming
    set_size(5'd1);
    no_idle = 1'b1;
    hold_req = HoldCycles;
    repeat (30) send_row(RowW'($urandom_range(0, 16'hFFFF)), 1'b1);
    no_idle = 1'b0;

    // random phases, one size setting each
    while (rows_loaded < TargetRows) begin
      case ($urandom_range(0, 7))
        0:       size_v = '0;
        1:       size_v = 5'd31;
        2:       size_v = 5'd1;
        3:       size_v = 5'd16;
        default: size_v = SizeW'($urandom_range(2, 31));
      endcase
      set_size(size_v);
      n_eff = (size_v == '0) ? 1 : ((int'(size_v) > MaxN) ? MaxN : int'(size_v));
      no_idle = ($urandom_range(0, 3) == 0);
      mats = $urandom_range(2, 8);
      repeat (mats) begin
        kind = $urandom_range(0, 9);
        rel = make_relation(n_eff);
        if (kind <= 6) begin
          // complete matrix
          for (i = 0; i < n_eff; i++) begin
            send_row(rel[i], i == n_eff - 1);
          end
        end else if (kind == 7) begin
          // trailing rows missing
          cnt = $urandom_range(1, n_eff);
          for (i = 0; i < cnt; i++) begin
            send_row(rel[i], i == cnt - 1);
          end
        end else if (kind == 8) begin
          // surplus rows, some past the store depth
          cnt = $urandom_range(n_eff + 1, 20);
          for (i = 0; i < cnt; i++) begin
            send_row((i < n_eff) ? rel[i] : RowW'($urandom_range(0, 16'hFFFF)),
                     i == cnt - 1);
          end
        end else begin
          // loose rows with a random end marker
          cnt = $urandom_range(1, 6);
          repeat (cnt) begin
            send_row(RowW'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3) == 0);
          end
        end
      end
      // rows left in the store across the next size change
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) send_row(RowW'($urandom_range(0, 16'hFFFF)), 1'b0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("relation_property_checker regression: pass");
    end else begin
      $display("relation_property_checker regression: fail");
    end
    $finish;
  end

endmodule
